### rtl/gda_pkg.sv
// gda_pkg: shared widths, status codes, calendar helpers and the command/status
// structs that pass between the gregorian date adder's controller and datapath
// no dependencies
package gda_pkg;

  localparam int DAY_W         = 5;
  localparam int MONTH_W       = 4;
  localparam int YEAR_W        = 14;
  localparam int STAT_W        = 2;
  localparam int ADD_WIDTH_DEF = 12;

  // year position within the 400-year cycle
  localparam int MOD_W = 9;

  // floor(y / 400) == (y * RECIP_400) >> RECIP_SHIFT for every 14-bit y
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 21;
  localparam int QUOT_W      = 6;
  localparam logic [RECIP_W-1:0] RECIP_400 = 13'd5243;
  localparam logic [MOD_W-1:0]   CYCLE_LEN = 9'd400;
  localparam logic [MOD_W-1:0]   CYCLE_END = 9'd399;
  localparam logic [MOD_W-1:0]   CENT_1    = 9'd100;
  localparam logic [MOD_W-1:0]   CENT_2    = 9'd200;
  localparam logic [MOD_W-1:0]   CENT_3    = 9'd300;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
  localparam logic [DAY_W-1:0]   LEN_31    = 5'd31;
  localparam logic [DAY_W-1:0]   LEN_30    = 5'd30;
  localparam logic [DAY_W-1:0]   LEN_29    = 5'd29;
  localparam logic [DAY_W-1:0]   LEN_28    = 5'd28;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic load;    // capture an accepted input word
    logic mul;     // reciprocal multiply for year / 400
    logic rem;     // remainder within the 400-year cycle
    logic check;   // validate and add the day count
    logic step;    // one month of the walk
    logic push;    // move the result to the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic invalid;    // start date fails validation
    logic walk_done;  // day fits within the current month
    logic out_full;   // output register holds a word not yet taken
  } dp_stat_t;

  function automatic logic is_leap(input logic [MOD_W-1:0] r400);
    logic cent;
    cent = (r400 == CENT_1) || (r400 == CENT_2) || (r400 == CENT_3);
    return (r400 == '0) || ((r400[1:0] == 2'b00) && !cent);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? LEN_29 : LEN_28;
    end else if ((m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) ||
                 (m == MONTH_NOV)) begin
      len = LEN_30;
    end else begin
      len = LEN_31;
    end
    return len;
  endfunction

endpackage

### rtl/gda_if.sv
// gda_in_if and gda_out_if: valid/ready channels for start-date words and
// result words of the gregorian date adder
// depends on gda_pkg
interface gda_in_if #(
  parameter int ADD_WIDTH = gda_pkg::ADD_WIDTH_DEF
) ();
  import gda_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DAY_W-1:0]     start_day;
  logic [MONTH_W-1:0]   start_month;
  logic [YEAR_W-1:0]    start_year;
  logic [ADD_WIDTH-1:0] days_to_add;

  modport source(output valid, start_day, start_month, start_year, days_to_add,
                 input ready);
  modport sink(input valid, start_day, start_month, start_year, days_to_add,
               output ready);
  modport mon(input valid, ready, start_day, start_month, start_year, days_to_add);
endinterface

interface gda_out_if ();
  import gda_pkg::*;

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   end_day;
  logic [MONTH_W-1:0] end_month;
  logic [YEAR_W-1:0]  end_year;
  logic [STAT_W-1:0]  status;

  modport source(output valid, end_day, end_month, end_year, status, input ready);
  modport sink(input valid, end_day, end_month, end_year, status, output ready);
  modport mon(input valid, ready, end_day, end_month, end_year, status);
endinterface

### rtl/gda_ctrl.sv
// gda_ctrl: sequencer for one date word at a time: setup, month walk, hand-off
// depends on gda_pkg
module gda_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gda_pkg::dp_stat_t    stat,
  output gda_pkg::ctrl_cmd_t   cmd
);
  import gda_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_REM;
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.invalid ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_full) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/gda_dp.sv
// gda_dp: date registers, year-in-cycle tracking, month walk and output register
// depends on gda_pkg
module gda_dp #(
  parameter int ADD_WIDTH = gda_pkg::ADD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gda_pkg::ctrl_cmd_t          cmd,
  output gda_pkg::dp_stat_t           stat,
  input  logic [gda_pkg::DAY_W-1:0]   start_day,
  input  logic [gda_pkg::MONTH_W-1:0] start_month,
  input  logic [gda_pkg::YEAR_W-1:0]  start_year,
  input  logic [ADD_WIDTH-1:0]        days_to_add,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gda_pkg::DAY_W-1:0]   end_day,
  output logic [gda_pkg::MONTH_W-1:0] end_month,
  output logic [gda_pkg::YEAR_W-1:0]  end_year,
  output logic [gda_pkg::STAT_W-1:0]  status
);
  import gda_pkg::*;

  // running day count: start day plus the whole addend, one bit of headroom
  localparam int DW = ((ADD_WIDTH > DAY_W) ? ADD_WIDTH : DAY_W) + 1;

  logic [DW-1:0]        d_r;
  logic [MONTH_W-1:0]   m_r;
  logic [YEAR_W-1:0]    y_r;
  logic [ADD_WIDTH-1:0] n_r;
  logic [STAT_W-1:0]    st_r;
  logic [QUOT_W-1:0]    q_r;
  logic [MOD_W-1:0]     r400_r;

  logic [DAY_W-1:0]   res_d_r;
  logic [MONTH_W-1:0] res_m_r;
  logic [YEAR_W-1:0]  res_y_r;
  logic [STAT_W-1:0]  res_st_r;
  logic               out_valid_r;

  logic [YEAR_W+RECIP_W-1:0] prod;
  logic [QUOT_W+MOD_W-1:0]   qmul;
  logic [YEAR_W-1:0]         rem_full;
  logic                      leap;
  logic [DAY_W-1:0]          len;
  logic [DW-1:0]             len_ext;
  logic                      bad_date;

  assign prod     = {{RECIP_W{1'b0}}, y_r} * {{YEAR_W{1'b0}}, RECIP_400};
  assign qmul     = {{MOD_W{1'b0}}, q_r} * {{QUOT_W{1'b0}}, CYCLE_LEN};
  assign rem_full = y_r - qmul[YEAR_W-1:0];

  assign leap    = is_leap(r400_r);
  assign len     = month_len(m_r, leap);
  assign len_ext = {{(DW-DAY_W){1'b0}}, len};

  assign bad_date = (m_r < MONTH_JAN) || (m_r > MONTH_DEC) ||
                    (y_r < YEAR_MIN) || (y_r > YEAR_MAX) ||
                    (d_r < {{(DW-DAY_W){1'b0}}, DAY_MIN}) || (d_r > len_ext);

  assign stat.invalid   = bad_date;
  assign stat.walk_done = (d_r <= len_ext);
  assign stat.out_full  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r <= {{(DW-DAY_W){1'b0}}, start_day};
      m_r <= start_month;
      y_r <= start_year;
      n_r <= days_to_add;
    end
    if (cmd.mul) begin
      q_r <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd.rem) begin
      r400_r <= rem_full[MOD_W-1:0];
    end
    if (cmd.check) begin
      if (bad_date) begin
        st_r <= STAT_INVALID;
      end else begin
        st_r <= STAT_OK;
        d_r  <= d_r + {{(DW-ADD_WIDTH){1'b0}}, n_r};
      end
    end
    if (cmd.step) begin
      if (m_r == MONTH_DEC) begin
        if (y_r == YEAR_MAX) begin
          // past the last representable year: pin to the final day
          d_r  <= {{(DW-DAY_W){1'b0}}, LEN_31};
          st_r <= STAT_OVERFLOW;
        end else begin
          d_r    <= d_r - len_ext;
          m_r    <= MONTH_JAN;
          y_r    <= y_r + 1'b1;
          r400_r <= (r400_r == CYCLE_END) ? '0 : r400_r + 1'b1;
        end
      end else begin
        d_r <= d_r - len_ext;
        m_r <= m_r + 1'b1;
      end
    end
    if (cmd.push) begin
      res_d_r  <= d_r[DAY_W-1:0];
      res_m_r  <= m_r;
      res_y_r  <= y_r;
      res_st_r <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign end_day   = res_d_r;
  assign end_month = res_m_r;
  assign end_year  = res_y_r;
  assign status    = res_st_r;

endmodule

### rtl/gregorian_date_add_days_core.sv
// Gregorian date adder: each input word gives a start date and a day count and
// produces one result word with the advanced date and a status code (0 ok,
// 1 invalid start date echoed unchanged, 2 saturated at 31/12/9999). Words are
// handled one at a time: the accepting state, then S_MUL and S_REM (year
// position within the 400-year leap cycle by reciprocal multiply) and S_CHECK
// (date validation and addition), then the datapath's month walk in S_WALK,
// stepping once per month boundary crossed and then checking the final month,
// and S_DONE, which loads the output register once it holds no untaken word;
// an invalid date skips the walk. A finished result waits in the output
// register while the next word is accepted.
// depends on gda_pkg, gda_if, gda_ctrl, gda_dp
module gregorian_date_add_days_core #(
  parameter int ADD_WIDTH = gda_pkg::ADD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gda_in_if.sink           in_ch,
  gda_out_if.source        out_ch
);
  import gda_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gda_dp #(
    .ADD_WIDTH (ADD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .start_day   (in_ch.start_day),
    .start_month (in_ch.start_month),
    .start_year  (in_ch.start_year),
    .days_to_add (in_ch.days_to_add),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .end_day     (out_ch.end_day),
    .end_month   (out_ch.end_month),
    .end_year    (out_ch.end_year),
    .status      (out_ch.status)
  );

endmodule

### rtl/gda_checker.sv
// gda_checker: port-level properties of the gregorian date adder, bound to the
// top level
// depends on gda_pkg, gda_if, gregorian_date_add_days_core
module gda_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gda_pkg::DAY_W-1:0]   end_day,
  input logic [gda_pkg::MONTH_W-1:0] end_month,
  input logic [gda_pkg::YEAR_W-1:0]  end_year,
  input logic [gda_pkg::STAT_W-1:0]  status
);
  import gda_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one word in flight: no acceptance in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == STAT_OK) || (status == STAT_INVALID) ||
                  (status == STAT_OVERFLOW))
    else $error("unknown status code");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_OVERFLOW) |->
      (end_day == LEN_31) && (end_month == MONTH_DEC) && (end_year == YEAR_MAX))
    else $error("overflow result not pinned to last day");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STAT_OK) |->
      (end_month >= MONTH_JAN) && (end_month <= MONTH_DEC) &&
      (end_day >= DAY_MIN) && (end_year >= YEAR_MIN) && (end_year <= YEAR_MAX))
    else $error("ok result outside calendar range");

endmodule

bind gregorian_date_add_days_core gda_checker u_gda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .end_day   (out_ch.end_day),
  .end_month (out_ch.end_month),
  .end_year  (out_ch.end_year),
  .status    (out_ch.status)
);
